// ----- hw/rtl/btc_pkg.sv -----
// ----------------------------------------------------------------------------
// btc_pkg: shared types and constants for the barycentric coverage unit
// Field widths, the weight saturation range and the per-item class bits
// passed from the front end through the queue to the divider back end.
// ----------------------------------------------------------------------------
package btc_pkg;

    localparam int COORD_W     = 16;
    localparam int PIXEL_W     = 12;
    localparam int AREA_W      = 16;
    localparam int AREA_FRAC   = 8;
    localparam int WEIGHT_W    = 18;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int DEN_W       = 2 * DIFF_W + 1;
    localparam int WEIGHT_MAX  = 131071;
    localparam int WEIGHT_MIN  = -131072;
    localparam logic [AREA_W-1:0] AREA_RESET = 16'd2;

    // per-item classification: degenerate flag and quotient signs
    typedef struct packed {
        logic degen;
        logic neg_a;
        logic neg_b;
        logic neg_c;
    } cls_t;

endpackage

// ----- hw/rtl/btc_front.sv -----
// ----------------------------------------------------------------------------
// btc_front: edge vectors, cross product and triangle classification
// Three register stages: differences, products, cross product terms. The
// last stage forms magnitudes, signs and the degenerate flag on the queue push.
// ----------------------------------------------------------------------------
module btc_front
    import btc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [COORD_W-1:0]  a_x,
    input  logic [COORD_W-1:0]  a_y,
    input  logic [COORD_W-1:0]  b_x,
    input  logic [COORD_W-1:0]  b_y,
    input  logic [COORD_W-1:0]  c_x,
    input  logic [COORD_W-1:0]  c_y,
    input  logic [PIXEL_W-1:0]  pixel_x,
    input  logic [PIXEL_W-1:0]  pixel_y,
    input  logic [AREA_W-1:0]   min_area,
    input  logic                q_full,
    output logic                q_push,
    output cls_t                q_cls,
    output logic [((((COORD_W > PIXEL_W + COORD_FRAC_BITS + 1) ? COORD_W
                   : PIXEL_W + COORD_FRAC_BITS + 1) + 1) + DIFF_W + 2)-1:0] q_mag_a,
    output logic [((((COORD_W > PIXEL_W + COORD_FRAC_BITS + 1) ? COORD_W
                   : PIXEL_W + COORD_FRAC_BITS + 1) + 1) + DIFF_W + 2)-1:0] q_mag_b,
    output logic [((((COORD_W > PIXEL_W + COORD_FRAC_BITS + 1) ? COORD_W
                   : PIXEL_W + COORD_FRAC_BITS + 1) + 1) + DIFF_W + 2)-1:0] q_mag_c,
    output logic [DEN_W-1:0]    q_mag_d
);

    localparam int PXW  = PIXEL_W + COORD_FRAC_BITS;
    localparam int ZW   = ((COORD_W > PXW + 1) ? COORD_W : PXW + 1) + 1;
    localparam int PW   = DIFF_W + ZW;
    localparam int UW   = PW + 1;
    localparam int SW   = UW + 1;
    localparam int LW   = DEN_W + AREA_FRAC;
    localparam int RHW  = AREA_W + 2 * COORD_FRAC_BITS;
    localparam int CMPW = (LW > RHW) ? LW : RHW;

    logic front_en;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [DIFF_W-1:0] s0x_reg, s0y_reg, s1x_reg, s1y_reg;
    logic signed [ZW-1:0]     s0z_reg, s1z_reg;
    logic signed [DIFF_W-1:0] s0x_next, s0y_next, s1x_next, s1y_next;
    logic signed [ZW-1:0]     s0z_next, s1z_next;
    logic [PXW-1:0]           px, py;

    logic signed [PW-1:0]        pux0_reg, pux1_reg, puy0_reg, puy1_reg;
    logic signed [2*DIFF_W-1:0]  puz0_reg, puz1_reg;
    logic signed [UW-1:0]        ux_reg, uy_reg;
    logic signed [DEN_W-1:0]     uz_reg;

    logic signed [SW-1:0]  sum_ab;
    logic signed [SW-1:0]  ux_ext, uy_ext;
    logic [CMPW-1:0]       lhs, rhs;

    // hold the whole front while the last stage cannot push
    assign front_en = !(s3_valid_reg && q_full);
    assign in_ready = front_en;
    assign q_push   = s3_valid_reg && !q_full;

    always_comb
    begin
        px       = PXW'(pixel_x) << COORD_FRAC_BITS;
        py       = PXW'(pixel_y) << COORD_FRAC_BITS;
        s0x_next = $signed({c_x[COORD_W-1], c_x}) - $signed({a_x[COORD_W-1], a_x});
        s0y_next = $signed({b_x[COORD_W-1], b_x}) - $signed({a_x[COORD_W-1], a_x});
        s1x_next = $signed({c_y[COORD_W-1], c_y}) - $signed({a_y[COORD_W-1], a_y});
        s1y_next = $signed({b_y[COORD_W-1], b_y}) - $signed({a_y[COORD_W-1], a_y});
        s0z_next = $signed({{(ZW-COORD_W){a_x[COORD_W-1]}}, a_x})
                 - $signed({{(ZW-PXW){1'b0}}, px});
        s1z_next = $signed({{(ZW-COORD_W){a_y[COORD_W-1]}}, a_y})
                 - $signed({{(ZW-PXW){1'b0}}, py});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            s0x_reg  <= s0x_next;
            s0y_reg  <= s0y_next;
            s0z_reg  <= s0z_next;
            s1x_reg  <= s1x_next;
            s1y_reg  <= s1y_next;
            s1z_reg  <= s1z_next;
            pux0_reg <= PW'(s0y_reg) * PW'(s1z_reg);
            pux1_reg <= PW'(s0z_reg) * PW'(s1y_reg);
            puy0_reg <= PW'(s0z_reg) * PW'(s1x_reg);
            puy1_reg <= PW'(s0x_reg) * PW'(s1z_reg);
            puz0_reg <= (2*DIFF_W)'(s0x_reg) * (2*DIFF_W)'(s1y_reg);
            puz1_reg <= (2*DIFF_W)'(s0y_reg) * (2*DIFF_W)'(s1x_reg);
            ux_reg   <= UW'(pux0_reg) - UW'(pux1_reg);
            uy_reg   <= UW'(puy0_reg) - UW'(puy1_reg);
            uz_reg   <= DEN_W'(puz0_reg) - DEN_W'(puz1_reg);
        end
    end

    always_comb
    begin
        ux_ext  = SW'(ux_reg);
        uy_ext  = SW'(uy_reg);
        sum_ab  = ux_ext + uy_ext;
        q_mag_a = sum_ab[SW-1] ? SW'(-sum_ab) : SW'(sum_ab);
        q_mag_b = uy_ext[SW-1] ? SW'(-uy_ext) : SW'(uy_ext);
        q_mag_c = ux_ext[SW-1] ? SW'(-ux_ext) : SW'(ux_ext);
        q_mag_d = uz_reg[DEN_W-1] ? DEN_W'(-uz_reg) : DEN_W'(uz_reg);
        lhs     = CMPW'({q_mag_d, {AREA_FRAC{1'b0}}});
        rhs     = CMPW'(min_area) << (2 * COORD_FRAC_BITS);
        q_cls.degen = (lhs <= rhs);
        q_cls.neg_a = sum_ab[SW-1] ^ uz_reg[DEN_W-1];
        q_cls.neg_b = uy_ext[SW-1] ^ uz_reg[DEN_W-1];
        q_cls.neg_c = ux_ext[SW-1] ^ uz_reg[DEN_W-1];
    end

endmodule

// ----- hw/rtl/btc_fifo.sv -----
// ----------------------------------------------------------------------------
// btc_fifo: short queue between the classification front and divider back
// Register array with read and write pointers and an occupancy count; the
// head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module btc_fifo
    import btc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ----- hw/rtl/btc_back.sv -----
// ----------------------------------------------------------------------------
// btc_back: pipelined restoring dividers, sign, saturation and output register
// Three lanes divide the weight numerators by |u.z|, one quotient bit a stage,
// and the last register applies signs, the one-minus term and saturation.
// ----------------------------------------------------------------------------
module btc_back
    import btc_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 16,
    parameter int NUM_W            = 37
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  cls_t                        head_cls,
    input  logic [NUM_W-1:0]            head_mag_a,
    input  logic [NUM_W-1:0]            head_mag_b,
    input  logic [NUM_W-1:0]            head_mag_c,
    input  logic [DEN_W-1:0]            head_mag_d,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        inside_res,
    output logic                        degenerate,
    output logic signed [WEIGHT_W-1:0]  weight_a,
    output logic signed [WEIGHT_W-1:0]  weight_b,
    output logic signed [WEIGHT_W-1:0]  weight_c
);

    localparam int WF  = WEIGHT_FRAC_BITS;
    localparam int QB  = ((WF > WEIGHT_W - 1) ? WF : WEIGHT_W - 1) + 2;
    localparam int SH  = QB - WF;
    localparam int RW  = DEN_W + 1;
    localparam int OVW = ((NUM_W > DEN_W + SH) ? NUM_W : DEN_W + SH) + 1;
    localparam int SQW = QB + 3;

    logic back_en;

    logic             valid_reg [0:QB];
    cls_t             cls_reg   [0:QB];
    logic [DEN_W-1:0] den_reg   [0:QB];
    logic [RW-1:0]    rem_reg   [0:QB][0:2];
    logic [QB-1:0]    quo_reg   [0:QB][0:2];
    logic [NUM_W-1:0] num_reg   [0:QB][0:2];
    logic             ovf_reg   [0:QB][0:2];

    logic [NUM_W-1:0] head_num [0:2];
    logic [RW-1:0]    rem_init [0:2];
    logic             ovf_init [0:2];

    logic                    out_valid_reg;
    logic                    inside_next, degen_next;
    logic signed [WEIGHT_W-1:0] wa_next, wb_next, wc_next;
    logic signed [WEIGHT_W-1:0] wa_reg, wb_reg, wc_reg;
    logic                    inside_reg, degen_reg;

    function automatic logic signed [WEIGHT_W-1:0] sat_w(input logic signed [SQW-1:0] v);
        logic signed [WEIGHT_W-1:0] r;
        if (v > SQW'(WEIGHT_MAX))
            r = WEIGHT_W'(WEIGHT_MAX);
        else if (v < SQW'(WEIGHT_MIN))
            r = WEIGHT_W'(WEIGHT_MIN);
        else
            r = WEIGHT_W'(v);
        return r;
    endfunction

    // advance the whole back end unless the result register is stalled
    assign back_en = !out_valid_reg || out_ready;
    assign pop     = head_valid && back_en;

    always_comb
    begin
        head_num[0] = head_mag_a;
        head_num[1] = head_mag_b;
        head_num[2] = head_mag_c;
        for (int l = 0; l < 3; l++)
        begin
            ovf_init[l] = OVW'(head_num[l]) >= (OVW'(head_mag_d) << SH);
            rem_init[l] = RW'(head_num[l] >> SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (back_en)
            valid_reg[0] <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            cls_reg[0] <= head_cls;
            den_reg[0] <= head_mag_d;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= rem_init[l];
                quo_reg[0][l] <= '0;
                num_reg[0][l] <= head_num[l];
                ovf_reg[0][l] <= ovf_init[l];
            end
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        localparam int BI = QB - k;
        logic [RW-1:0] shifted [0:2];
        logic [RW-1:0] rem_next [0:2];
        logic          qbit [0:2];
        logic          bit_in [0:2];

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (BI >= WF && BI - WF < NUM_W)
                    bit_in[l] = num_reg[k-1][l][(BI >= WF) ? BI - WF : 0];
                else
                    bit_in[l] = 1'b0;
                shifted[l] = {rem_reg[k-1][l][RW-2:0], bit_in[l]};
                qbit[l]    = (shifted[l] >= {1'b0, den_reg[k-1]});
                rem_next[l] = qbit[l] ? shifted[l] - {1'b0, den_reg[k-1]} : shifted[l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (back_en)
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (back_en)
            begin
                cls_reg[k] <= cls_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[k][l] <= rem_next[l];
                    quo_reg[k][l] <= {quo_reg[k-1][l][QB-2:0], qbit[l]};
                    num_reg[k][l] <= num_reg[k-1][l];
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
            end
        end
    end

    always_comb
    begin
        logic [QB-1:0]        q [0:2];
        logic signed [SQW-1:0] qs [0:2];
        logic                  neg [0:2];
        neg[0] = cls_reg[QB].neg_a;
        neg[1] = cls_reg[QB].neg_b;
        neg[2] = cls_reg[QB].neg_c;
        for (int l = 0; l < 3; l++)
        begin
            // clamp an overflowed quotient; saturation gives the same result
            q[l]  = ovf_reg[QB][l] ? {QB{1'b1}} : quo_reg[QB][l];
            qs[l] = neg[l] ? -$signed({3'b000, q[l]}) : $signed({3'b000, q[l]});
        end
        degen_next = cls_reg[QB].degen;
        if (degen_next)
        begin
            wa_next = '0;
            wb_next = '0;
            wc_next = '0;
        end
        else
        begin
            wa_next = sat_w((SQW'(1) << WF) - qs[0]);
            wb_next = sat_w(qs[1]);
            wc_next = sat_w(qs[2]);
        end
        inside_next = !degen_next && !wa_next[WEIGHT_W-1]
                    && !wb_next[WEIGHT_W-1] && !wc_next[WEIGHT_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (back_en)
            out_valid_reg <= valid_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            inside_reg <= inside_next;
            degen_reg  <= degen_next;
            wa_reg     <= wa_next;
            wb_reg     <= wb_next;
            wc_reg     <= wc_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign degenerate = degen_reg;
    assign weight_a   = wa_reg;
    assign weight_b   = wb_reg;
    assign weight_c   = wc_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> !inside_res && weight_a == '0
            && weight_b == '0 && weight_c == '0)
        else $error("degenerate result with nonzero weights");

    a_inside_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> !weight_a[WEIGHT_W-1]
            && !weight_b[WEIGHT_W-1] && !weight_c[WEIGHT_W-1])
        else $error("inside set with a negative weight");

endmodule

// ----- hw/rtl/barycentric_triangle_coverage.sv -----
// ----------------------------------------------------------------------------
// barycentric_triangle_coverage: pixel coverage test against one triangle
// Cross product classification front, item queue, pipelined divider back end.
// ----------------------------------------------------------------------------
// Accepts one pixel/triangle beat per clock while in_ready is high and returns
// one result beat per input, in order. The path runs through three front stages,
// the queue, the restoring divider stages of the back end (one quotient bit per
// stage) and the result register.
// Sustained rate is one item per cycle while out_ready stays high; min_area is
// written through the cfg channel, which is always ready, and resets to 2.
module barycentric_triangle_coverage
    import btc_pkg::*;
#(
    parameter int COORD_FRAC_BITS  = 4,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [AREA_W-1:0]           cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_W-1:0]          a_x,
    input  logic [COORD_W-1:0]          a_y,
    input  logic [COORD_W-1:0]          b_x,
    input  logic [COORD_W-1:0]          b_y,
    input  logic [COORD_W-1:0]          c_x,
    input  logic [COORD_W-1:0]          c_y,
    input  logic [PIXEL_W-1:0]          pixel_x,
    input  logic [PIXEL_W-1:0]          pixel_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        inside_res,
    output logic                        degenerate,
    output logic signed [WEIGHT_W-1:0]  weight_a,
    output logic signed [WEIGHT_W-1:0]  weight_b,
    output logic signed [WEIGHT_W-1:0]  weight_c
);

    localparam int PXW   = PIXEL_W + COORD_FRAC_BITS;
    localparam int ZW    = ((COORD_W > PXW + 1) ? COORD_W : PXW + 1) + 1;
    localparam int SW    = DIFF_W + ZW + 2;
    localparam int QW    = $bits(cls_t) + 3 * SW + DEN_W;
    localparam int DEPTH = 4;

    logic [AREA_W-1:0] min_area_reg;

    logic             q_full, q_push, q_pop, q_head_valid;
    cls_t             push_cls, head_cls;
    logic [SW-1:0]    push_a, push_b, push_c;
    logic [DEN_W-1:0] push_d;
    logic [QW-1:0]    push_data, head_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_area_reg <= AREA_RESET;
        else if (cfg_valid)
            min_area_reg <= cfg_data;
    end

    btc_front #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .a_x      (a_x),
        .a_y      (a_y),
        .b_x      (b_x),
        .b_y      (b_y),
        .c_x      (c_x),
        .c_y      (c_y),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .min_area (min_area_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cls    (push_cls),
        .q_mag_a  (push_a),
        .q_mag_b  (push_b),
        .q_mag_c  (push_c),
        .q_mag_d  (push_d)
    );

    assign push_data = {push_cls, push_a, push_b, push_c, push_d};

    btc_fifo #(
        .WIDTH(QW),
        .DEPTH(DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (head_data)
    );

    assign head_cls = cls_t'(head_data[QW-1 -: $bits(cls_t)]);

    btc_back #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
        .NUM_W           (SW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cls   (head_cls),
        .head_mag_a (head_data[DEN_W + 2*SW +: SW]),
        .head_mag_b (head_data[DEN_W + SW +: SW]),
        .head_mag_c (head_data[DEN_W +: SW]),
        .head_mag_d (head_data[DEN_W-1:0]),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .degenerate (degenerate),
        .weight_a   (weight_a),
        .weight_b   (weight_b),
        .weight_c   (weight_c)
    );

endmodule
